/* rtl/sfd_pkg.sv */
// Shared types, constants and check function for the serial frame deframer.
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CHECK_POLY    = 8'h8C;
  localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hAA;
  localparam logic [BYTE_W-1:0] LENGTH_RESET  = 8'h08;
  localparam logic [BYTE_W-1:0] TARGETS_RESET = 8'h01;
  localparam logic [BYTE_W-1:0] CHECK_RESET   = 8'h00;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_CRC_ERR = 2'd1;
  localparam status_t ST_UNKNOWN = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SYNC    = 2'd0;
  localparam cfg_idx_t REG_LENGTH  = 2'd1;
  localparam cfg_idx_t REG_TARGETS = 2'd2;

  typedef logic [2:0] pos_t;
  localparam pos_t POS_SYNC   = 3'd0;
  localparam pos_t POS_LEN    = 3'd1;
  localparam pos_t POS_ID     = 3'd2;
  localparam pos_t POS_L_LO   = 3'd3;
  localparam pos_t POS_L_HI   = 3'd4;
  localparam pos_t POS_R_LO   = 3'd5;
  localparam pos_t POS_R_HI   = 3'd6;
  localparam pos_t POS_CHECK  = 3'd7;

  // Reflected CRC-8 update, one byte, LSB first.
  function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] acc_in,
                                                   input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] d;
    acc = acc_in;
    d   = data;
    for (int i = 0; i < BYTE_W; i++) begin
      if ((acc[0] ^ d[0]) == 1'b1) begin
        acc = (acc >> 1) ^ CHECK_POLY;
      end else begin
        acc = acc >> 1;
      end
      d = d >> 1;
    end
    return acc;
  endfunction

endpackage

/* rtl/serial_frame_deframer_crc8.sv */
// Top level: byte-stream frame parser with CRC-8 check and result register.
// A result is registered in the result register once the check byte has passed the input register.
// Throughput: one byte request per cycle; the input register and the result register
// decouple the two sides, so a waiting result holds back only the next check byte.
// Reset (rst, synchronous, active high): parser waits for sync, check cleared,
// registers return to sync 0xAA, length 0x08, target count 1; no result pending.
`timescale 1ns / 1ps
module serial_frame_deframer_crc8 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  sfd_pkg::cfg_idx_t             cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sfd_pkg::status_t              status,
  output logic [sfd_pkg::BYTE_W-1:0]    target_id,
  output logic signed [sfd_pkg::SPEED_W-1:0] left_speed,
  output logic signed [sfd_pkg::SPEED_W-1:0] right_speed,
  output logic [sfd_pkg::BYTE_W-1:0]    received_check,
  output logic [sfd_pkg::BYTE_W-1:0]    computed_check
);
  import sfd_pkg::*;

  logic [BYTE_W-1:0] sync_byte;
  logic [BYTE_W-1:0] length_byte;
  logic [BYTE_W-1:0] target_count;

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_q;

  pos_t              pos;
  pos_t              pos_next;
  logic [BYTE_W-1:0] crc;
  logic [BYTE_W-1:0] crc_next;
  logic [BYTE_W-1:0] crc_base;
  logic [BYTE_W-1:0] crc_upd;

  logic [BYTE_W-1:0] id_b;
  logic [BYTE_W-1:0] l_lo;
  logic [BYTE_W-1:0] l_hi;
  logic [BYTE_W-1:0] r_lo;
  logic [BYTE_W-1:0] r_hi;

  logic              fire;
  logic              emit;
  status_t           status_next;

  // only the check byte needs room in the result register
  assign fire     = byte_valid && ((pos != POS_CHECK) || !out_valid || !out_stall);
  assign in_stall = byte_valid && !fire;
  assign emit     = fire && (pos == POS_CHECK);

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte    <= SYNC_RESET;
      length_byte  <= LENGTH_RESET;
      target_count <= TARGETS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC:    sync_byte    <= cfg_data;
        REG_LENGTH:  length_byte  <= cfg_data;
        REG_TARGETS: target_count <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q <= rx_byte;
    end
  end

  // Parser step
  always_comb begin
    crc_base = crc;
    if (pos == POS_SYNC || (pos == POS_LEN && byte_q != length_byte)) begin
      crc_base = CHECK_RESET;
    end
  end

  assign crc_upd = crc_update(crc_base, byte_q);

  always_comb begin
    pos_next = pos;
    crc_next = crc;
    case (pos)
      POS_SYNC: begin
        if (byte_q == sync_byte) begin
          pos_next = POS_LEN;
          crc_next = crc_upd;
        end
      end
      POS_LEN: begin
        if (byte_q == length_byte) begin
          pos_next = POS_ID;
          crc_next = crc_upd;
        end else if (byte_q == sync_byte) begin
          pos_next = POS_LEN;
          crc_next = crc_upd;
        end else begin
          pos_next = POS_SYNC;
          crc_next = CHECK_RESET;
        end
      end
      POS_CHECK: begin
        pos_next = POS_SYNC;
        crc_next = CHECK_RESET;
      end
      default: begin
        pos_next = pos + 3'd1;
        crc_next = crc_upd;
      end
    endcase
  end

  always_comb begin
    if (crc != byte_q) begin
      status_next = ST_CRC_ERR;
    end else if (id_b < target_count) begin
      status_next = ST_OK;
    end else begin
      status_next = ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_SYNC;
      crc <= CHECK_RESET;
    end else if (fire) begin
      pos <= pos_next;
      crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      unique case (pos)
        POS_ID:   id_b <= byte_q;
        POS_L_LO: l_lo <= byte_q;
        POS_L_HI: l_hi <= byte_q;
        POS_R_LO: r_lo <= byte_q;
        POS_R_HI: r_hi <= byte_q;
        default:  ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status         <= status_next;
      target_id      <= id_b;
      left_speed     <= signed'({l_hi, l_lo});
      right_speed    <= signed'({r_hi, r_lo});
      received_check <= byte_q;
      computed_check <= crc;
    end
  end

endmodule

/* rtl/sfd_checker.sv */
// Port-level checker for the frame deframer, bound to the top level.
`timescale 1ns / 1ps
module sfd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sfd_pkg::status_t              status,
  input  logic [sfd_pkg::BYTE_W-1:0]    received_check,
  input  logic [sfd_pkg::BYTE_W-1:0]    computed_check
);
  import sfd_pkg::*;

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result pending after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_CRC_ERR || status == ST_UNKNOWN))
    else $error("bad status code");

  a_crc_err_mismatch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_CRC_ERR) |-> (received_check != computed_check))
    else $error("crc error flagged on matching check");

  a_good_crc_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_CRC_ERR) |-> (received_check == computed_check))
    else $error("good status on mismatching check");

endmodule

bind serial_frame_deframer_crc8 sfd_checker u_sfd_checker (.*);
